FILE: rtl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg: shared types and constants
// Sizes and sequencer states for the trial-division factorizer.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_FACTORS = 9;
  localparam int IN_BITS     = 32;
  localparam int PRIME_BITS  = 32;

  // used width of the value, trial divisor, its square
  localparam int X_BITS    = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int D_BITS    = (X_BITS + 1) / 2 + 1;
  localparam int SQ_BITS   = 2 * D_BITS;
  localparam int CNT_BITS  = $clog2(MAX_FACTORS + 1);
  localparam int STEP_BITS = $clog2(X_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_EVAL,
    ST_FINAL
  } tdpf_state_t;

endpackage

FILE: rtl/trial_division_prime_factors.sv
// ----------------------------------------------------------------------------
// trial_division_prime_factors
// Emits the distinct prime factors of an unsigned value in ascending order.
// ----------------------------------------------------------------------------
// Raise start with in_value while busy is low. Values 0 and 1 give one result
// (none=1, last=1) in the next cycle and never raise busy. Otherwise busy
// stays high while divisors 2, 3 and then odd values are tried through one
// shared restoring divider that retires one quotient bit per cycle. For each
// trial divisor its square is compared with the value (ST_TEST), then the
// value is divided (ST_DIV) and the remainder evaluated (ST_EVAL); each
// further division by a found factor repeats ST_DIV and ST_EVAL. Each factor
// is shown for exactly one cycle on out_valid; the receiver cannot stall, and
// the final result of an item carries out_last.
// ----------------------------------------------------------------------------
module trial_division_prime_factors
  import tdpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_BITS-1:0]    in_value,
  output logic                  out_valid,
  output logic [PRIME_BITS-1:0] out_prime,
  output logic                  out_none,
  output logic                  out_last
);

  tdpf_state_t            state_r, state_nxt;
  logic                   busy_r, busy_nxt;
  logic [X_BITS-1:0]      x_r, x_nxt;
  logic [D_BITS-1:0]      d_r, d_nxt;
  logic [SQ_BITS-1:0]     sq_r, sq_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic                   hit_r, hit_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [X_BITS-1:0]      pend_r, pend_nxt;
  logic [X_BITS-1:0]      q_r, q_nxt;
  logic [D_BITS-1:0]      rem_r, rem_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic                   ov_r, ov_nxt;
  logic [PRIME_BITS-1:0]  oprime_r, oprime_nxt;
  logic                   onone_r, onone_nxt;
  logic                   olast_r, olast_nxt;

  logic [X_BITS-1:0]      x_in;
  logic [D_BITS:0]        trial;
  logic                   fits;

  assign x_in  = in_value[X_BITS-1:0];
  assign trial = {rem_r, q_r[X_BITS-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= 1'b0;
      ov_r     <= 1'b0;
      count_r  <= '0;
      hit_r    <= 1'b0;
      pend_v_r <= 1'b0;
      step_r   <= '0;
      x_r      <= '0;
      d_r      <= D_BITS'(2);
      sq_r     <= SQ_BITS'(4);
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      ov_r     <= ov_nxt;
      count_r  <= count_nxt;
      hit_r    <= hit_nxt;
      pend_v_r <= pend_v_nxt;
      step_r   <= step_nxt;
      x_r      <= x_nxt;
      d_r      <= d_nxt;
      sq_r     <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    oprime_r <= oprime_nxt;
    onone_r  <= onone_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    x_nxt      = x_r;
    d_nxt      = d_r;
    sq_nxt     = sq_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    ov_nxt     = 1'b0;
    oprime_nxt = oprime_r;
    onone_nxt  = 1'b0;
    olast_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start && !busy_r) begin
          x_nxt = x_in;
          d_nxt = D_BITS'(2);
          sq_nxt = SQ_BITS'(4);
          if (x_in < X_BITS'(2)) begin
            ov_nxt     = 1'b1;
            oprime_nxt = '0;
            onone_nxt  = 1'b1;
            olast_nxt  = 1'b1;
          end else begin
            busy_nxt   = 1'b1;
            count_nxt  = '0;
            hit_nxt    = 1'b0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_TEST;
          end
        end
      end

      ST_TEST: begin
        if (sq_r <= SQ_BITS'(x_r) && count_r < CNT_BITS'(MAX_FACTORS)) begin
          q_nxt     = x_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else if (x_r > X_BITS'(1) && count_r < CNT_BITS'(MAX_FACTORS)) begin
          // leftover cofactor is prime; flush any held factor first
          ov_nxt     = pend_v_r;
          oprime_nxt = PRIME_BITS'(pend_r);
          pend_nxt   = x_r;
          pend_v_nxt = 1'b1;
          state_nxt  = ST_FINAL;
        end else begin
          ov_nxt     = 1'b1;
          oprime_nxt = PRIME_BITS'(pend_r);
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          busy_nxt   = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      ST_DIV: begin
        q_nxt   = {q_r[X_BITS-2:0], fits};
        rem_nxt = fits ? D_BITS'(trial - {1'b0, d_r}) : trial[D_BITS-1:0];
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(X_BITS - 1)) begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (rem_r == '0) begin
          x_nxt    = q_r;
          q_nxt    = q_r;
          rem_nxt  = '0;
          step_nxt = '0;
          if (!hit_r) begin
            hit_nxt    = 1'b1;
            count_nxt  = count_r + CNT_BITS'(1);
            ov_nxt     = pend_v_r;
            oprime_nxt = PRIME_BITS'(pend_r);
            pend_nxt   = X_BITS'(d_r);
            pend_v_nxt = 1'b1;
          end
          state_nxt = ST_DIV;
        end else begin
          hit_nxt = 1'b0;
          if (d_r == D_BITS'(2)) begin
            d_nxt  = D_BITS'(3);
            sq_nxt = SQ_BITS'(9);
          end else begin
            d_nxt  = d_r + D_BITS'(2);
            sq_nxt = sq_r + (SQ_BITS'(d_r) << 2) + SQ_BITS'(4);
          end
          state_nxt = ST_TEST;
        end
      end

      ST_FINAL: begin
        ov_nxt     = 1'b1;
        oprime_nxt = PRIME_BITS'(pend_r);
        olast_nxt  = 1'b1;
        pend_v_nxt = 1'b0;
        busy_nxt   = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        busy_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
    endcase
  end

  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign out_prime = oprime_r;
  assign out_none  = onone_r;
  assign out_last  = olast_r;

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && onone_r) |-> olast_r)
    else $error("none result without last");

  a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (ov_r && olast_r && !onone_r))
    else $error("search ended without a final result");

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_EVAL) |-> (d_r[0] || d_r == D_BITS'(2)))
    else $error("trial divisor is even and not two");

  a_work_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> busy_r)
    else $error("sequencer active while not busy");

  a_factor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !onone_r) |-> (oprime_r > PRIME_BITS'(1)))
    else $error("emitted factor below two");

endmodule
